// ----- rtl/rdre_pkg.sv -----
// Package for the rough diffuse reflectance evaluator.
// Holds the fixed-point constants, register indexes and the divider step.
// No dependencies.
package rdre_pkg;

    localparam int FRAC_BITS  = 15;
    localparam int FIELD_W    = 16;
    localparam int DOT_W      = 32;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DOT_W / DIV_STEP;
    localparam int G_W        = 2 * FIELD_W + 2;
    localparam int P_W        = G_W + FIELD_W - FRAC_BITS;
    localparam int V_W        = P_W + FIELD_W - 16;

    localparam logic [15:0] INV_PI_Q16 = 16'd20861;
    localparam logic [15:0] TOP_VALUE  = 16'hFFFF;

    typedef enum logic [2:0] {
        REG_RHO_RED   = 3'd0,
        REG_RHO_GREEN = 3'd1,
        REG_RHO_BLUE  = 3'd2,
        REG_COEFF_A   = 3'd3,
        REG_COEFF_B   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic               valid;
        logic               zero;
        logic [FIELD_W-1:0] den;
        logic [FIELD_W-1:0] rem;
        logic [DOT_W-1:0]   dq;
    } div_slot_t;

    // DIV_STEP restoring steps; dq shifts the dividend out and quotient in
    function automatic div_slot_t div_step(input div_slot_t s);
        div_slot_t       r;
        logic [FIELD_W:0] t;
        r = s;
        for (int i = 0; i < DIV_STEP; i++) begin
            t = {r.rem, r.dq[DOT_W-1]};
            r.dq = {r.dq[DOT_W-2:0], 1'b0};
            if (t >= {1'b0, r.den}) begin
                t = t - {1'b0, r.den};
                r.dq[0] = 1'b1;
            end
            r.rem = t[FIELD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/rough_diffuse_reflectance_eval.sv -----
// Rough diffuse (Oren-Nayar, qualitative) reflectance evaluator, top level.
// Depends on rdre_pkg.
// Throughput: one beat per cycle while the result beat is not stalled.
// The 32-bit divide is an 8-stage pipeline, 4 quotient bits per stage.
// The whole pipe advances together; it stalls only when the result beat waits.
// Synchronous active-low reset clears valid bits and loads register defaults.
module rough_diffuse_reflectance_eval
    import rdre_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // out_x, out_y, out_z, in_x, in_y, in_z
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // refl_red, refl_green, refl_blue
    output logic [47:0]  m_tdata,
    // saturated
    output logic         m_tuser
);

    logic [15:0] rho_r_reg, rho_g_reg, rho_b_reg, coeff_a_reg, coeff_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rho_r_reg   <= 16'd32768;
            rho_g_reg   <= 16'd32768;
            rho_b_reg   <= 16'd32768;
            coeff_a_reg <= 16'd32768;
            coeff_b_reg <= 16'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RHO_RED:   rho_r_reg   <= cfg_wr_data;
                REG_RHO_GREEN: rho_g_reg   <= cfg_wr_data;
                REG_RHO_BLUE:  rho_b_reg   <= cfg_wr_data;
                REG_COEFF_A:   coeff_a_reg <= cfg_wr_data;
                REG_COEFF_B:   coeff_b_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 1: products and divisor
    logic               v1_reg, z1_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [15:0]        den1_reg;
    logic signed [15:0] ox, oy, oz, ix, iy, iz;
    logic [15:0]        azo, azi, den1_next;

    assign ox = s_tdata[15:0];
    assign oy = s_tdata[31:16];
    assign oz = s_tdata[47:32];
    assign ix = s_tdata[63:48];
    assign iy = s_tdata[79:64];
    assign iz = s_tdata[95:80];
    assign azo = oz[15] ? 16'(-oz) : 16'(oz);
    assign azi = iz[15] ? 16'(-iz) : 16'(iz);
    assign den1_next = (azi > azo) ? azi : azo;

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= s_tvalid;
        if (en) begin
            px_reg   <= ix * ox;
            py_reg   <= iy * oy;
            den1_reg <= den1_next;
            z1_reg   <= (den1_next == 16'd0);
        end
    end

    // stage 2: dot product, clamp to positive
    div_slot_t          slot_reg [DIV_STAGES+1];
    div_slot_t          slot0_next;
    logic signed [32:0] dot;

    assign dot = 33'(px_reg) + 33'(py_reg);
    always_comb begin
        slot0_next.valid = v1_reg;
        slot0_next.zero  = z1_reg;
        slot0_next.den   = den1_reg;
        slot0_next.rem   = '0;
        slot0_next.dq    = (dot > 33'sd0) ? dot[DOT_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) slot_reg[0].valid <= 1'b0;
        else if (en)  slot_reg[0] <= slot0_next;
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) slot_reg[k+1].valid <= 1'b0;
            else if (en)  slot_reg[k+1] <= div_step(slot_reg[k]);
        end
    end

    // coeff_b * term
    logic        vb_reg, zb_reg;
    logic [47:0] bt_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vb_reg <= 1'b0;
        else if (en)  vb_reg <= slot_reg[DIV_STAGES].valid;
        if (en) begin
            zb_reg <= slot_reg[DIV_STAGES].zero;
            bt_reg <= coeff_b_reg * slot_reg[DIV_STAGES].dq;
        end
    end

    // g = (A<<F + B*term) >> F
    logic           vg_reg, zg_reg;
    logic [G_W-1:0] g_reg;
    logic [48:0]    s_sum;
    assign s_sum = {coeff_a_reg, {FRAC_BITS{1'b0}}} + 49'(bt_reg);
    always_ff @(posedge aclk) begin
        if (!aresetn) vg_reg <= 1'b0;
        else if (en)  vg_reg <= vb_reg;
        if (en) begin
            zg_reg <= zb_reg;
            g_reg  <= s_sum[FRAC_BITS +: G_W];
        end
    end

    // p = rho * g >> F
    logic                    vp_reg, zp_reg;
    logic [P_W-1:0]          p_reg [3];
    logic [G_W+FIELD_W-1:0]  pr [3];
    assign pr[0] = rho_r_reg * g_reg;
    assign pr[1] = rho_g_reg * g_reg;
    assign pr[2] = rho_b_reg * g_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vp_reg <= 1'b0;
        else if (en)  vp_reg <= vg_reg;
        if (en) begin
            zp_reg <= zg_reg;
            for (int c = 0; c < 3; c++) p_reg[c] <= pr[c][FRAC_BITS +: P_W];
        end
    end

    // v = p / pi
    logic           vv_reg, zv_reg;
    logic [V_W-1:0] v_reg [3];
    logic [P_W+15:0] vr [3];
    for (genvar c = 0; c < 3; c++) begin : g_inv
        assign vr[c] = p_reg[c] * INV_PI_Q16;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) vv_reg <= 1'b0;
        else if (en)  vv_reg <= vp_reg;
        if (en) begin
            zv_reg <= zp_reg;
            for (int c = 0; c < 3; c++) v_reg[c] <= vr[c][16 +: V_W];
        end
    end

    // clip and output register
    logic        out_v_reg, out_z_reg, out_sat_reg;
    logic [47:0] out_d_reg;
    logic [47:0] out_d_next;
    logic        out_sat_next;
    always_comb begin
        out_sat_next = zv_reg;
        out_d_next   = '0;
        for (int c = 0; c < 3; c++) begin
            if (zv_reg || v_reg[c] > V_W'(TOP_VALUE)) begin
                out_d_next[16*c +: 16] = TOP_VALUE;
                out_sat_next = 1'b1;
            end else begin
                out_d_next[16*c +: 16] = v_reg[c][15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (en)  out_v_reg <= vv_reg;
        if (en) begin
            out_d_reg   <= out_d_next;
            out_sat_reg <= out_sat_next;
            out_z_reg   <= zv_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tuser  = out_sat_reg;

    a_zero_div: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_z_reg |-> m_tuser && m_tdata == {3{TOP_VALUE}})
        else $error("zero divisor result not saturated");

    a_ready: assert property (@(posedge aclk)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output stall");

    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("valid after reset");

endmodule

// ----- test/testbench.sv -----
// Testbench for rough_diffuse_reflectance_eval: random and directed direction pairs,
// with register changes between phases. A scoreboard class predicts each result beat.
// Depends on rdre_pkg and the RTL top level.
module testbench;
    import rdre_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        sat;
    } refl_t;

    class refl_scoreboard;
        logic [15:0] rho_r, rho_g, rho_b, ca, cb;
        refl_t pending[$];
        int mismatches;
        int checked;

        function void reset_regs();
            rho_r = 16'd32768;
            rho_g = 16'd32768;
            rho_b = 16'd32768;
            ca = 16'd32768;
            cb = 16'd0;
        endfunction

        function void write_reg(reg_index_t idx, logic [15:0] val);
            case (idx)
                REG_RHO_RED:   rho_r = val;
                REG_RHO_GREEN: rho_g = val;
                REG_RHO_BLUE:  rho_b = val;
                REG_COEFF_A:   ca = val;
                REG_COEFF_B:   cb = val;
                default: ;
            endcase
        endfunction

        function logic [15:0] shade(logic [15:0] rho, logic [63:0] g, ref logic clip);
            logic [63:0] p, v;
            p = ({48'd0, rho} * g) >> 15;
            v = (p * 64'd20861) >> 16;
            if (v > 64'hFFFF) begin
                clip = 1'b1;
                return 16'hFFFF;
            end
            return v[15:0];
        endfunction

        function void note_input(logic [95:0] d);
            longint ox, oy, oz, ix, iy, iz, dot, aiz, aoz, den;
            logic [63:0] term, g;
            logic clip;
            refl_t r;
            ox = $signed(d[15:0]);
            oy = $signed(d[31:16]);
            oz = $signed(d[47:32]);
            ix = $signed(d[63:48]);
            iy = $signed(d[79:64]);
            iz = $signed(d[95:80]);
            aiz = iz < 0 ? -iz : iz;
            aoz = oz < 0 ? -oz : oz;
            den = aiz > aoz ? aiz : aoz;
            dot = ix * ox + iy * oy;
            clip = 1'b0;
            if (den == 0) begin
                r = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
            end else begin
                term = dot > 0 ? dot / den : 0;
                g = (({48'd0, ca} << 15) + {48'd0, cb} * term) >> 15;
                r.red = shade(rho_r, g, clip);
                r.green = shade(rho_g, g, clip);
                r.blue = shade(rho_b, g, clip);
                r.sat = clip;
            end
            pending.push_back(r);
        endfunction

        function void check_result(refl_t act);
            refl_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", act);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e !== act) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp r=%h g=%h b=%h s=%b act r=%h g=%h b=%h s=%b",
                             e.red, e.green, e.blue, e.sat,
                             act.red, act.green, act.blue, act.sat);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    refl_scoreboard sb;
    int sent;
    int hold_cycles = 0;
    bit stall_on = 1'b1;

    always #5 aclk = ~aclk;

    rough_diffuse_reflectance_eval dut (.*);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result({m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser});
    end

    // receiver: own stall pattern, plus a single long hold-off set by the test
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (!stall_on) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_beat(logic [95:0] d);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(d);
        sent++;
    endtask

    task automatic idle(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_cfg(reg_index_t idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [95:0] rand_dirs();
        logic [95:0] d;
        for (int i = 0; i < 6; i++) d[16*i +: 16] = rand_comp();
        if ($urandom_range(0, 15) == 0) begin
            d[47:32] = '0;
            d[95:80] = '0;
        end
        return d;
    endfunction

    task automatic random_phase(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && n > 0) begin
                send_beat(rand_dirs());
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 6));
        end
    endtask

    task automatic set_all(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                           logic [15:0] a, logic [15:0] c);
        write_cfg(REG_RHO_RED, r);
        write_cfg(REG_RHO_GREEN, g);
        write_cfg(REG_RHO_BLUE, b);
        write_cfg(REG_COEFF_A, a);
        write_cfg(REG_COEFF_B, c);
    endtask

    initial begin
        sb = new();
        sb.reset_regs();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero divisor, negative dot, extremes
        send_beat({16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h7FFF});
        send_beat({16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF});
        send_beat({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
        send_beat({16'h0001, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h7FFF, 16'h7FFF});
        send_beat({16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000});
        drain();
        set_all(16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF, 16'hFFFF);
        send_beat({16'h0001, 16'h8000, 16'h8000, 16'h0001, 16'h8000, 16'h8000});
        send_beat({16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF});
        send_beat({16'h4000, 16'h2000, 16'h2000, 16'hC000, 16'h2000, 16'h2000});
        send_beat({16'h5A82, 16'h0000, 16'h5A82, 16'h5A82, 16'h0000, 16'h5A82});
        drain();

        // long hold-off so the pipe fills and back-pressures the input
        hold_cycles = 60;
        random_phase(60);
        drain();

        set_all(16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd0);
        random_phase(400);
        drain();
        set_all(16'd20000, 16'd12000, 16'd30000, 16'd16000, 16'd32768);
        random_phase(400);
        drain();
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(300);
        drain();
        set_all(16'd0, 16'd1, 16'd65535, 16'd0, 16'd40000);
        stall_on = 1'b0;
        random_phase(300);
        drain();
        stall_on = 1'b1;
        set_all(16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)));
        random_phase(380);
        drain();

        $display("Covered %0d direction pairs over six register settings, %0d results checked.",
                 sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/rdre_pkg.sv
rtl/rough_diffuse_reflectance_eval.sv
test/testbench.sv
